// ===== hdl/rdav_pkg.sv =====
// Package for the range digit assign block: widths, modulus, modular helpers.
// Used by rdav_digit_mem and range_digit_assign_modular_value_core.
`timescale 1ns / 1ps
package rdav_pkg;

  localparam int unsigned VAL_W          = 30;
  localparam int unsigned POS_W          = 11;
  localparam int unsigned DIG_W          = 4;
  localparam int unsigned MAX_DIGITS_DEF = 1024;
  localparam int unsigned LEN_RESET      = 1024;
  localparam logic [DIG_W-1:0] DIGIT_MAX = 4'd9;
  localparam logic [DIG_W-1:0] TEN       = 4'd10;
  localparam logic [VAL_W-1:0] PRIME     = 30'd998244353;

  // k * w mod PRIME for a 4-bit k and a reduced w; quotient is at most 15
  function automatic logic [VAL_W-1:0] mul_small_mod(input logic [DIG_W-1:0] k,
                                                      input logic [VAL_W-1:0] w);
    logic [33:0] prod;
    logic [33:0] res;
    logic        hit;
    prod = 34'(k) * 34'(w);
    res  = prod;
    hit  = 1'b0;
    for (int q = 15; q >= 1; q--) begin
      if (!hit && (prod >= 34'(q) * 34'(PRIME))) begin
        res = prod - 34'(q) * 34'(PRIME);
        hit = 1'b1;
      end
    end
    return res[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] add_mod(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PRIME}) s = s - {1'b0, PRIME};
    return s[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] sub_mod(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    if (a >= b) s = {1'b0, a} - {1'b0, b};
    else        s = {1'b0, a} + {1'b0, PRIME} - {1'b0, b};
    return s[VAL_W-1:0];
  endfunction

endpackage

// ===== hdl/rdav_digit_mem.sv =====
// Digit store: one decimal digit per position, one write and one read port.
// Read data is registered. Uses rdav_pkg.
`timescale 1ns / 1ps
module rdav_digit_mem #(
  parameter int unsigned DEPTH = rdav_pkg::MAX_DIGITS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [rdav_pkg::DIG_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [rdav_pkg::DIG_W-1:0] rdata
);

  logic [rdav_pkg::DIG_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/range_digit_assign_modular_value_core.sv =====
// Top level of the range digit assign block: controller, weight walk, value update.
// Depends on rdav_pkg and rdav_digit_mem.
//
// Usage:
//   The block holds a decimal number of number_length digits, position 1 most
//   significant, and its value modulo 998244353. cfg_valid/cfg_ready/cfg_data
//   write number_length (0 reads as 1, above MAX_DIGITS clamps); that and reset
//   start a clearing pass that sets all digits to 1, during which in_ready is low.
//   cfg_ready is always high.
//   An input beat (in_left, in_right, in_digit) assigns the digit to the range;
//   the result beat carries the new value and range_error.
//   A valid range walks the digit memory from the last position down to in_left,
//   one position a cycle, then settles through a drain state to the done state;
//   a rejected range goes straight to the done state. The walk reads one position
//   at a time through the single read port of the digit memory.
//   One item at a time; the result sits in an output register. If the receiver
//   stalls, the finished item holds in the controller until the register frees.
`timescale 1ns / 1ps
module range_digit_assign_modular_value_core #(
  parameter int unsigned MAX_DIGITS = rdav_pkg::MAX_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rdav_pkg::POS_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rdav_pkg::POS_W-1:0]  in_left,
  input  logic [rdav_pkg::POS_W-1:0]  in_right,
  input  logic [rdav_pkg::DIG_W-1:0]  in_digit,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rdav_pkg::VAL_W-1:0]  out_number_value,
  output logic                        out_range_error
);

  localparam int unsigned AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned LW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned CW = (LW > rdav_pkg::POS_W) ? LW : rdav_pkg::POS_W;
  localparam int unsigned RESET_LEN =
    (MAX_DIGITS < rdav_pkg::LEN_RESET) ? MAX_DIGITS : rdav_pkg::LEN_RESET;

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_WALK, ST_DRAIN, ST_DONE} state_t;

  state_t                       state_r;
  logic [LW-1:0]                len_r;
  logic [LW-1:0]                len_nxt;
  logic [LW-1:0]                clr_r;
  logic [LW-1:0]                pos_r;
  logic [LW-1:0]                pos_m1;
  logic [CW-1:0]                left_r;
  logic [CW-1:0]                right_r;
  logic [rdav_pkg::DIG_W-1:0]   dig_r;
  logic [rdav_pkg::VAL_W-1:0]   w_r;
  logic [rdav_pkg::VAL_W-1:0]   value_r;
  logic [rdav_pkg::VAL_W-1:0]   value_nxt;
  logic                         err_r;
  logic                         s1_valid_r;
  logic                         s1_in_r;
  logic [AW-1:0]                s1_addr_r;
  logic [rdav_pkg::VAL_W-1:0]   s1_w_r;
  logic                         out_valid_r;
  logic [rdav_pkg::VAL_W-1:0]   out_value_r;
  logic                         out_err_r;

  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [rdav_pkg::DIG_W-1:0]   mem_wdata;
  logic [AW-1:0]                mem_raddr;
  logic [rdav_pkg::DIG_W-1:0]   mem_rdata;

  logic [CW-1:0]                cfg_ext;
  logic [CW-1:0]                in_left_ext;
  logic [CW-1:0]                in_right_ext;
  logic [CW-1:0]                len_ext;
  logic                         in_err;
  logic [rdav_pkg::DIG_W-1:0]   in_dig_sat;

  assign cfg_ready        = 1'b1;
  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_number_value = out_value_r;
  assign out_range_error  = out_err_r;

  // length clamp and range check
  assign cfg_ext      = CW'(cfg_data);
  assign in_left_ext  = CW'(in_left);
  assign in_right_ext = CW'(in_right);
  assign len_ext      = CW'(len_r);

  always_comb begin
    if (cfg_ext == '0)                     len_nxt = LW'(1);
    else if (cfg_ext > CW'(MAX_DIGITS))    len_nxt = LW'(MAX_DIGITS);
    else                                   len_nxt = cfg_ext[LW-1:0];
  end

  assign in_err = (in_left_ext == '0) || (in_left_ext > in_right_ext) ||
                  (in_right_ext > len_ext);
  assign in_dig_sat = (in_digit > rdav_pkg::DIGIT_MAX) ? rdav_pkg::DIGIT_MAX : in_digit;

  assign pos_m1    = pos_r - LW'(1);
  assign mem_raddr = pos_m1[AW-1:0];

  // memory write port: clearing pass or read-modify-write of the walk
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = s1_addr_r;
    mem_wdata = dig_r;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r[AW-1:0];
      mem_wdata = rdav_pkg::DIG_W'(1);
    end else if (s1_valid_r && s1_in_r) begin
      mem_we = 1'b1;
    end
  end

  // value update: swap old digit's term for the new one
  always_comb begin
    value_nxt = value_r;
    if (s1_valid_r && s1_in_r) begin
      value_nxt = rdav_pkg::sub_mod(
                    rdav_pkg::add_mod(value_r, rdav_pkg::mul_small_mod(dig_r, s1_w_r)),
                    rdav_pkg::mul_small_mod(mem_rdata, s1_w_r));
    end
  end

  rdav_digit_mem #(
    .DEPTH (MAX_DIGITS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // controller
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      len_r       <= LW'(RESET_LEN);
      clr_r       <= '0;
      value_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      err_r       <= 1'b0;
    end else begin
      s1_valid_r <= 1'b0;
      if (out_ready) out_valid_r <= 1'b0;
      value_r <= value_nxt;

      if (cfg_valid) begin
        len_r   <= len_nxt;
        clr_r   <= '0;
        value_r <= '0;
        state_r <= ST_CLEAR;
      end else begin
        unique case (state_r)
          ST_CLEAR: begin
            value_r <= rdav_pkg::add_mod(rdav_pkg::mul_small_mod(rdav_pkg::TEN, value_r),
                                         rdav_pkg::VAL_W'(1));
            clr_r   <= clr_r + LW'(1);
            if (clr_r + LW'(1) == len_r) state_r <= ST_IDLE;
          end
          ST_IDLE: begin
            if (in_valid) begin
              left_r  <= in_left_ext;
              right_r <= in_right_ext;
              dig_r   <= in_dig_sat;
              err_r   <= in_err;
              pos_r   <= len_r;
              w_r     <= rdav_pkg::VAL_W'(1);
              state_r <= in_err ? ST_DONE : ST_WALK;
            end
          end
          ST_WALK: begin
            s1_valid_r <= 1'b1;
            s1_addr_r  <= pos_m1[AW-1:0];
            s1_w_r     <= w_r;
            s1_in_r    <= (CW'(pos_r) <= right_r);
            w_r        <= rdav_pkg::mul_small_mod(rdav_pkg::TEN, w_r);
            pos_r      <= pos_m1;
            if (CW'(pos_r) == left_r) state_r <= ST_DRAIN;
          end
          ST_DRAIN: begin
            state_r <= ST_DONE;
          end
          ST_DONE: begin
            if (!out_valid_r || out_ready) begin
              out_valid_r <= 1'b1;
              out_value_r <= value_r;
              out_err_r   <= err_r;
              state_r     <= ST_IDLE;
            end
          end
          default: state_r <= ST_IDLE;
        endcase
      end
    end
  end

endmodule

// ===== verif/range_digit_assign_modular_value_core_test.sv =====
// Testbench for range_digit_assign_modular_value_core: directed table plus random
// range assigns, checked against a digit-array predictor. Depends on rdav_pkg.
`timescale 1ns / 1ps
module range_digit_assign_modular_value_core_test;

  localparam int unsigned LIMIT_CYCLES = 3000000;
  localparam int unsigned POS_W        = rdav_pkg::POS_W;
  localparam int unsigned DIG_W        = rdav_pkg::DIG_W;
  localparam int unsigned VAL_W        = rdav_pkg::VAL_W;
  localparam int unsigned MAXD         = rdav_pkg::MAX_DIGITS_DEF;
  localparam logic [DIG_W-1:0] DIGIT_MAX = rdav_pkg::DIGIT_MAX;
  localparam logic [VAL_W-1:0] PRIME     = rdav_pkg::PRIME;

  typedef struct {
    logic [POS_W-1:0] left;
    logic [POS_W-1:0] right;
    logic [DIG_W-1:0] digit;
    bit               known;
    logic [VAL_W-1:0] val;
    bit               err;
  } assign_beat_t;

  typedef struct {
    logic [VAL_W-1:0] val;
    bit               err;
  } number_result_t;

  // directed row: digit count for the row, then the beat
  typedef struct {
    int unsigned  len;
    assign_beat_t beat;
  } table_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [POS_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [POS_W-1:0] in_left = '0;
  logic [POS_W-1:0] in_right = '0;
  logic [DIG_W-1:0] in_digit = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [VAL_W-1:0] out_number_value;
  logic             out_range_error;

  range_digit_assign_modular_value_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_left(in_left), .in_right(in_right), .in_digit(in_digit),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_number_value(out_number_value), .out_range_error(out_range_error)
  );

  // predictor state: one digit per position, position 0 most significant
  logic [DIG_W-1:0] digits[MAXD];
  int unsigned      num_len;

  assign_beat_t     beat_q[$];
  assign_beat_t     offer_q[$];
  assign_beat_t     cur_beat;
  number_result_t   value_q[$];
  int unsigned      errors = 0;
  int unsigned      accepted = 0;
  int unsigned      results = 0;
  int unsigned      cfg_writes = 0;
  int unsigned      cycles = 0;
  int unsigned      hold_left = 0;
  bit               pressure_req = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // clear to all ones at a written length
  function automatic void load_length(input logic [POS_W-1:0] v);
    int unsigned n;
    n = v;
    if (n < 1) n = 1;
    if (n > MAXD) n = MAXD;
    num_len = n;
    for (int i = 0; i < MAXD; i++) digits[i] = 4'd1;
  endfunction

  function automatic number_result_t apply_assign(input assign_beat_t b);
    number_result_t   r;
    longint unsigned  acc;
    logic [DIG_W-1:0] d;
    d = (b.digit > DIGIT_MAX) ? DIGIT_MAX : b.digit;
    r.err = (b.left < 1) || (b.left > b.right) || (b.right > num_len);
    if (!r.err)
      for (int i = b.left - 1; i < b.right; i++) digits[i] = d;
    acc = 0;
    for (int i = 0; i < num_len; i++) acc = (acc * 10 + digits[i]) % PRIME;
    r.val = acc[VAL_W-1:0];
    return r;
  endfunction

  // run-time limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // sender: bursts of beats with random gaps
  int unsigned burst_left = 4;
  int unsigned gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
      // hold the offered beat
    end else if (gap_left > 0) begin
      gap_left = gap_left - 1;
      in_valid <= 1'b0;
    end else if (beat_q.size() > 0) begin
      cur_beat = beat_q.pop_front();
      offer_q.push_back(cur_beat);
      in_left  <= cur_beat.left;
      in_right <= cur_beat.right;
      in_digit <= cur_beat.digit;
      in_valid <= 1'b1;
      burst_left = burst_left - 1;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 10);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: stall pattern of its own, plus one long hold-off
  int unsigned stretch_left = 0;
  int unsigned stall_mode = 0;
  always @(posedge clk) begin
    if (pressure_req && hold_left == 0) begin
      hold_left = 600;
      pressure_req = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(5, 80);
        stall_mode = $urandom_range(0, 2);
      end
      stretch_left = stretch_left - 1;
      case (stall_mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          out_ready <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // accept monitor: predict on each input beat
  always @(posedge clk) begin
    number_result_t r;
    assign_beat_t   b;
    if (rst_n && in_valid && in_ready) begin
      b = offer_q.pop_front();
      r = apply_assign(b);
      if (b.known) begin
        r.val = b.val;
        r.err = b.err;
      end
      value_q.push_back(r);
      accepted++;
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    number_result_t e;
    if (rst_n && out_valid && out_ready) begin
      results++;
      if (value_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat value=%0d err=%0b", $time,
                 out_number_value, out_range_error);
      end else begin
        e = value_q.pop_front();
        if (out_number_value !== e.val) begin
          errors++;
          $display("%0t: number_value expected %0d actual %0d", $time, e.val,
                   out_number_value);
        end
        if (out_range_error !== e.err) begin
          errors++;
          $display("%0t: range_error expected %0b actual %0b", $time, e.err,
                   out_range_error);
        end
      end
    end
  end

  task automatic wait_idle();
    while (beat_q.size() > 0 || offer_q.size() > 0 || value_q.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_length(input logic [POS_W-1:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    load_length(v);
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  function automatic assign_beat_t rand_beat(input int unsigned n);
    assign_beat_t b;
    b.known = 0;
    b.val = '0;
    b.err = 0;
    b.digit = DIG_W'($urandom_range(0, 15));
    if ($urandom_range(0, 99) < 85) begin
      b.left  = POS_W'($urandom_range(1, n));
      b.right = ($urandom_range(0, 4) == 0) ? POS_W'(n) :
                POS_W'($urandom_range(b.left, n));
    end else begin
      b.left  = POS_W'($urandom_range(0, 2047));
      b.right = POS_W'($urandom_range(0, 2047));
    end
    return b;
  endfunction

  function automatic table_row_t row(input int unsigned len, input int unsigned l,
                                     input int unsigned r, input int unsigned d,
                                     input bit known, input int unsigned v,
                                     input bit err);
    table_row_t t;
    t.len = len;
    t.beat.left = POS_W'(l);
    t.beat.right = POS_W'(r);
    t.beat.digit = DIG_W'(d);
    t.beat.known = known;
    t.beat.val = VAL_W'(v);
    t.beat.err = err;
    return t;
  endfunction

  initial begin
    table_row_t  dir[$];
    int unsigned lens[$];
    int unsigned n;
    int unsigned count;

    // predictor starts at the reset length
    load_length(POS_W'(rdav_pkg::LEN_RESET));
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset length first, then the extremes of the range
    dir.push_back(row(1024, 1, 1025, 3, 0, 0, 0));
    dir.push_back(row(1024, 0, 5, 3, 0, 0, 0));
    dir.push_back(row(1024, 1, 1024, 0, 1, 0, 0));
    dir.push_back(row(1024, 1024, 1024, 7, 1, 7, 0));
    dir.push_back(row(1024, 2047, 2047, 2, 1, 7, 1));
    dir.push_back(row(1024, 9, 8, 2, 1, 7, 1));
    dir.push_back(row(1024, 1, 1, 15, 0, 0, 0));
    dir.push_back(row(1024, 500, 700, 4, 0, 0, 0));
    dir.push_back(row(1, 1, 1, 5, 1, 5, 0));
    dir.push_back(row(1, 1, 1, 15, 1, 9, 0));
    dir.push_back(row(1, 1, 1, 10, 1, 9, 0));
    dir.push_back(row(1, 0, 1, 3, 1, 9, 1));
    dir.push_back(row(1, 1, 2, 3, 1, 9, 1));
    dir.push_back(row(1, 1, 1, 0, 1, 0, 0));
    dir.push_back(row(2, 1, 2, 9, 1, 99, 0));
    dir.push_back(row(2, 2, 2, 0, 1, 90, 0));
    dir.push_back(row(2, 2, 1, 4, 1, 90, 1));
    dir.push_back(row(2, 1, 1, 12, 1, 90, 0));
    dir.push_back(row(2, 2, 2, 8, 0, 0, 0));

    n = 1024;
    foreach (dir[i]) begin
      if (dir[i].len != n) begin
        n = dir[i].len;
        write_length(POS_W'(n));
      end
      beat_q.push_back(dir[i].beat);
    end

    // random phases: extremes and out-of-range lengths, most of them small
    lens = '{0, 2047, 1, 2, 1024, 37, 5, 200, 13, 64, 3, 100};
    foreach (lens[p]) begin
      write_length(POS_W'(lens[p]));
      n = num_len;
      count = (n >= 200) ? 30 : 50;
      if (p == 7) pressure_req = 1;
      for (int k = 0; k < count; k++) beat_q.push_back(rand_beat(n));
    end

    wait_idle();
    repeat (1100) @(posedge clk);
    $display("Run covered %0d assign beats, %0d results, %0d length writes.",
             accepted, results, cfg_writes);
    $display("Lengths from 1 to %0d, bad ranges and saturated digits included.", MAXD);
    if (errors == 0 && value_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rdav_pkg.sv
hdl/rdav_digit_mem.sv
hdl/range_digit_assign_modular_value_core.sv
verif/range_digit_assign_modular_value_core_test.sv
